>>> hw/rtl/dga_pkg.sv
// ----------------------------------------------------------------------------
// dga_pkg: shared types, constants and arithmetic steps
// Beat formats, register codes and the single-step square root used by the
// distance gain attenuator pipeline.
// ----------------------------------------------------------------------------
package dga_pkg;

	// Field widths
	localparam int COORD_BITS = 20;
	localparam int RAD_W      = COORD_BITS - 1;
	localparam int ROLL_W     = 12;
	localparam int GAIN_W     = 16;
	localparam int CFG_W      = RAD_W;
	localparam int CFG_IDX_W  = 3;

	// Register reset values and limits
	localparam logic [GAIN_W-1:0] ONE_Q15     = 16'h8000;
	localparam logic [ROLL_W-1:0] MIN_ROLLOFF = 12'd26;
	localparam logic [ROLL_W-1:0] ROLLOFF_RST = 12'd512;
	localparam logic [RAD_W-1:0]  INNER_RST   = 19'd256;
	localparam logic [RAD_W-1:0]  OUTER_RST   = 19'd12800;

	// Distance square root: two result bits per stage
	localparam int MAG_W     = COORD_BITS;
	localparam int SQ_W      = 2 * MAG_W;
	localparam int SUM_W     = SQ_W + 2;
	localparam int DS_STAGES = (SUM_W + 3) / 4;
	localparam int DRAD_W    = 4 * DS_STAGES;
	localparam int DROOT_W   = 2 * DS_STAGES;

	// Ratio divider: three quotient bits per stage
	localparam int DIV_STEPS = 15;
	localparam int DIV_PER   = 3;
	localparam int DV_STAGES = DIV_STEPS / DIV_PER;

	// Log2 by repeated squaring, one square per stage
	localparam int LOG_STEPS = 16;
	localparam int LX_W      = 31;
	localparam int LP_W      = 2 * LX_W;
	localparam int LOG_W     = 20;

	// Exp2 by sixteen chained square roots, four root bits per stage
	localparam int EXP_STEPS = 16;
	localparam int EXP_PER   = 4;
	localparam int EXP_PAIRS = 32;
	localparam int EXP_SUB   = EXP_PAIRS / EXP_PER;
	localparam int EX_STAGES = EXP_STEPS * EXP_SUB;
	localparam logic [32:0] EXP_ONE = 33'h0_4000_0000;

	// Register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INNER      = 3'd0,
		REG_OUTER      = 3'd1,
		REG_ROLLOFF    = 3'd2,
		REG_CHAN_GAIN  = 3'd3,
		REG_MASTER     = 3'd4,
		REG_POSITIONAL = 3'd5
	} cfg_reg_e;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] source_x;
		logic signed [COORD_BITS-1:0] source_y;
		logic signed [COORD_BITS-1:0] source_z;
		logic signed [COORD_BITS-1:0] listener_x;
		logic signed [COORD_BITS-1:0] listener_y;
		logic signed [COORD_BITS-1:0] listener_z;
	} in_beat_t;

	typedef struct packed {
		logic [GAIN_W-1:0] attenuation;
		logic [GAIN_W-1:0] applied_gain;
	} out_beat_t;

	// Early decision on the attenuation, carried down the pipe
	typedef struct packed {
		logic one;
		logic zero;
	} att_force_t;

	// Partial remainder and root of a restoring square root
	typedef struct packed {
		logic [35:0] rem;
		logic [31:0] root;
	} sqrt_acc_t;

	// Take one root bit from the next pair of radicand bits
	function automatic sqrt_acc_t sqrt_step(input sqrt_acc_t a, input logic [1:0] pair);
		logic [35:0] rs;
		logic [35:0] trial;
		sqrt_acc_t   o;
		rs    = {a.rem[33:0], pair};
		trial = {2'b00, a.root, 2'b01};
		if (rs >= trial) begin
			o.rem  = rs - trial;
			o.root = {a.root[30:0], 1'b1};
		end else begin
			o.rem  = rs;
			o.root = {a.root[30:0], 1'b0};
		end
		return o;
	endfunction

endpackage

>>> hw/rtl/distance_gain_attenuator.sv
// ----------------------------------------------------------------------------
// distance_gain_attenuator: distance roll-off and source gain
// Takes a source and a listener position per beat and returns the distance
// attenuation and the resulting source gain, one beat per clock unless out_stall holds a result.
// ----------------------------------------------------------------------------
// The block accepts one position beat per clock and returns one result beat
// for each, in order, through 169 register stages. The depth is set by
// the arithmetic chain: an 11-stage distance square root, a 5-stage divider,
// 16 squaring stages for the log2, and 128 stages for the exp2 (sixteen
// chained 32-bit square roots at four root bits per stage). The whole pipe
// moves as one: while out_valid is high and out_stall is high nothing
// advances and in_stall is raised; otherwise every stage advances, bubbles
// included. Write registers only when no beat is in flight.
module distance_gain_attenuator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  dga_pkg::in_beat_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output dga_pkg::out_beat_t            out_data,
	input  logic                          cfg_we,
	input  logic [dga_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dga_pkg::CFG_W-1:0]     cfg_data
);
	import dga_pkg::*;

	localparam int NST   = 3 + DS_STAGES + 1 + DV_STAGES + 1 + LOG_STEPS + 2 + EX_STAGES + 2;
	localparam int V_EXL = NST - 3;

	logic adv;
	logic [NST-1:0] vld_s;

	// Configuration registers
	logic [RAD_W-1:0]    inner_q;
	logic [RAD_W-1:0]    outer_q;
	logic [ROLL_W-1:0]   rolloff_q;
	logic [GAIN_W-1:0]   chan_gain_q;
	logic [GAIN_W-1:0]   master_q;
	logic                positional_q;
	logic [GAIN_W-1:0]   base_gain_q;
	logic [2*GAIN_W-1:0] mg_prod;
	logic [RAD_W-1:0]    den_c;

	// Advance the whole pipe unless the result beat is held
	assign adv       = !out_valid || !out_stall;
	assign in_stall  = !adv;
	assign out_valid = vld_s[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NST-2:0], in_valid};
		end
	end

	// Write configuration, saturating as each register requires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q      <= INNER_RST;
			outer_q      <= OUTER_RST;
			rolloff_q    <= ROLLOFF_RST;
			chan_gain_q  <= ONE_Q15;
			master_q     <= ONE_Q15;
			positional_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INNER:      inner_q <= cfg_data[RAD_W-1:0];
				REG_OUTER:      outer_q <= cfg_data[RAD_W-1:0];
				REG_ROLLOFF:    rolloff_q <= (cfg_data[ROLL_W-1:0] < MIN_ROLLOFF) ?
					MIN_ROLLOFF : cfg_data[ROLL_W-1:0];
				REG_CHAN_GAIN:  chan_gain_q <= (cfg_data[GAIN_W-1:0] > ONE_Q15) ?
					ONE_Q15 : cfg_data[GAIN_W-1:0];
				REG_MASTER:     master_q <= (cfg_data[GAIN_W-1:0] > ONE_Q15) ?
					ONE_Q15 : cfg_data[GAIN_W-1:0];
				REG_POSITIONAL: positional_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Hold master times channel gain ready for the output stage
	assign mg_prod = master_q * chan_gain_q;
	assign den_c   = outer_q - inner_q;

	always_ff @(posedge clk) begin
		base_gain_q <= mg_prod[30:15];
	end

	// ------------------------------------------------------------------
	// Stages 1 to 3: axis differences, squares, sum
	// ------------------------------------------------------------------
	logic signed [COORD_BITS-1:0] src_c [3];
	logic signed [COORD_BITS-1:0] lis_c [3];
	logic signed [COORD_BITS:0]   dif_c [3];
	logic [COORD_BITS:0]          abs_c [3];
	logic [MAG_W-1:0]             mag_s1 [3];
	logic [SQ_W-1:0]              sq_c [3];
	logic [SQ_W-1:0]              sq_s2 [3];
	logic [SUM_W-1:0]             sum_s3;

	always_comb begin
		src_c[0] = in_data.source_x;
		src_c[1] = in_data.source_y;
		src_c[2] = in_data.source_z;
		lis_c[0] = in_data.listener_x;
		lis_c[1] = in_data.listener_y;
		lis_c[2] = in_data.listener_z;
		for (int a = 0; a < 3; a++) begin
			dif_c[a] = (COORD_BITS+1)'(src_c[a]) - (COORD_BITS+1)'(lis_c[a]);
			abs_c[a] = dif_c[a][COORD_BITS] ? -dif_c[a] : dif_c[a];
			sq_c[a]  = mag_s1[a] * mag_s1[a];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				mag_s1[a] <= abs_c[a][MAG_W-1:0];
				sq_s2[a]  <= sq_c[a];
			end
			sum_s3 <= SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]);
		end
	end

	// ------------------------------------------------------------------
	// Distance square root, two root bits per stage
	// ------------------------------------------------------------------
	sqrt_acc_t         ds_acc_s [DS_STAGES];
	logic [DRAD_W-1:0] ds_rad_s [DS_STAGES];

	for (genvar i = 0; i < DS_STAGES; i++) begin : g_ds
		sqrt_acc_t         a_in;
		sqrt_acc_t         a_out;
		logic [DRAD_W-1:0] r_in;
		if (i == 0) begin : g_first
			assign a_in = '0;
			assign r_in = DRAD_W'(sum_s3);
		end else begin : g_next
			assign a_in = ds_acc_s[i-1];
			assign r_in = ds_rad_s[i-1];
		end
		always_comb begin
			a_out = a_in;
			for (int m = 0; m < 2; m++) begin
				a_out = sqrt_step(a_out, r_in[DRAD_W-1-2*(2*i+m) -: 2]);
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				ds_acc_s[i] <= a_out;
				ds_rad_s[i] <= r_in;
			end
		end
	end

	// ------------------------------------------------------------------
	// Compare the distance with the radii
	// ------------------------------------------------------------------
	logic [DROOT_W-1:0] dist_c;
	logic               degen_c;
	logic               near_c;
	logic               far_c;
	att_force_t         cmp_frc_c;
	att_force_t         cmp_frc_s;
	logic [RAD_W-1:0]   cmp_rem_s;

	always_comb begin
		dist_c         = ds_acc_s[DS_STAGES-1].root[DROOT_W-1:0];
		degen_c        = (outer_q == '0) || (outer_q <= inner_q);
		near_c         = dist_c <= DROOT_W'(inner_q);
		far_c          = dist_c >= DROOT_W'(outer_q);
		cmp_frc_c.one  = degen_c || near_c;
		cmp_frc_c.zero = !cmp_frc_c.one && far_c;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmp_frc_s <= cmp_frc_c;
			cmp_rem_s <= outer_q - dist_c[RAD_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Restoring divider for t, three quotient bits per stage
	// ------------------------------------------------------------------
	logic [RAD_W-1:0]     dv_rem_s [DV_STAGES];
	logic [DIV_STEPS-1:0] dv_q_s   [DV_STAGES];
	att_force_t           dv_frc_s [DV_STAGES];

	for (genvar i = 0; i < DV_STAGES; i++) begin : g_dv
		logic [RAD_W-1:0]     rem_in;
		logic [DIV_STEPS-1:0] q_in;
		att_force_t           frc_in;
		logic [RAD_W-1:0]     rem_out;
		logic [DIV_STEPS-1:0] q_out;
		if (i == 0) begin : g_first
			assign rem_in = cmp_rem_s;
			assign q_in   = '0;
			assign frc_in = cmp_frc_s;
		end else begin : g_next
			assign rem_in = dv_rem_s[i-1];
			assign q_in   = dv_q_s[i-1];
			assign frc_in = dv_frc_s[i-1];
		end
		always_comb begin
			logic [RAD_W:0] rs;
			rem_out = rem_in;
			q_out   = q_in;
			for (int k = 0; k < DIV_PER; k++) begin
				rs = {rem_out, 1'b0};
				if (rs >= {1'b0, den_c}) begin
					rs    = rs - {1'b0, den_c};
					q_out = {q_out[DIV_STEPS-2:0], 1'b1};
				end else begin
					q_out = {q_out[DIV_STEPS-2:0], 1'b0};
				end
				rem_out = rs[RAD_W-1:0];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_rem_s[i] <= rem_out;
				dv_q_s[i]   <= q_out;
				dv_frc_s[i] <= frc_in;
			end
		end
	end

	// ------------------------------------------------------------------
	// Normalise t into [1,2)
	// ------------------------------------------------------------------
	logic [GAIN_W-1:0] t16_c;
	logic [GAIN_W-1:0] tm_c;
	logic [3:0]        tsh_c;
	logic              tfound_c;
	att_force_t        nrm_frc_c;
	logic [LX_W-1:0]   nrm_x_s;
	logic [3:0]        nrm_sh_s;
	att_force_t        nrm_frc_s;

	always_comb begin
		t16_c    = {1'b0, dv_q_s[DV_STAGES-1]};
		tsh_c    = '0;
		tfound_c = 1'b0;
		for (int k = GAIN_W - 1; k >= 0; k--) begin
			if (t16_c[k] && !tfound_c) begin
				tsh_c    = 4'(GAIN_W - 1 - k);
				tfound_c = 1'b1;
			end
		end
		tm_c           = t16_c << tsh_c;
		nrm_frc_c.one  = dv_frc_s[DV_STAGES-1].one;
		nrm_frc_c.zero = dv_frc_s[DV_STAGES-1].zero ||
			(!dv_frc_s[DV_STAGES-1].one && !tfound_c);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nrm_x_s   <= {tm_c, 15'b0};
			nrm_sh_s  <= tsh_c;
			nrm_frc_s <= nrm_frc_c;
		end
	end

	// ------------------------------------------------------------------
	// Log2 fraction by repeated squaring, one square per stage
	// ------------------------------------------------------------------
	logic [LP_W-1:0]      lg_prod_s [LOG_STEPS];
	logic [LOG_STEPS-1:0] lg_frac_s [LOG_STEPS];
	logic [3:0]           lg_sh_s   [LOG_STEPS];
	att_force_t           lg_frc_s  [LOG_STEPS];

	for (genvar j = 0; j < LOG_STEPS; j++) begin : g_lg
		logic [LX_W-1:0]      x_in;
		logic [LOG_STEPS-1:0] frac_in;
		logic [3:0]           sh_in;
		att_force_t           frc_in;
		logic [LP_W-1:0]      prod;
		if (j == 0) begin : g_first
			assign x_in    = nrm_x_s;
			assign frac_in = '0;
			assign sh_in   = nrm_sh_s;
			assign frc_in  = nrm_frc_s;
		end else begin : g_next
			logic [31:0] y;
			assign y       = lg_prod_s[j-1][LP_W-1:30];
			assign x_in    = y[31] ? y[31:1] : y[30:0];
			assign frac_in = {lg_frac_s[j-1][LOG_STEPS-2:0], y[31]};
			assign sh_in   = lg_sh_s[j-1];
			assign frc_in  = lg_frc_s[j-1];
		end
		assign prod = x_in * x_in;
		always_ff @(posedge clk) begin
			if (adv) begin
				lg_prod_s[j] <= prod;
				lg_frac_s[j] <= frac_in;
				lg_sh_s[j]   <= sh_in;
				lg_frc_s[j]  <= frc_in;
			end
		end
	end

	// Take the last fraction bit and form -log2(t)
	logic [31:0]          lf_y_c;
	logic [LOG_STEPS-1:0] lf_frac_c;
	logic [LOG_W-1:0]     lf_l_s;
	att_force_t           lf_frc_s;

	assign lf_y_c    = lg_prod_s[LOG_STEPS-1][LP_W-1:30];
	assign lf_frac_c = {lg_frac_s[LOG_STEPS-1][LOG_STEPS-2:0], lf_y_c[31]};

	always_ff @(posedge clk) begin
		if (adv) begin
			lf_l_s   <= {lg_sh_s[LOG_STEPS-1], 16'b0} - {4'b0, lf_frac_c};
			lf_frc_s <= lg_frc_s[LOG_STEPS-1];
		end
	end

	// ------------------------------------------------------------------
	// Scale by the roll-off exponent
	// ------------------------------------------------------------------
	logic [ROLL_W+LOG_W-1:0] pw_prod_c;
	logic [7:0]              pw_n_s;
	logic [15:0]             pw_f_s;
	att_force_t              pw_frc_s;

	assign pw_prod_c = rolloff_q * lf_l_s;

	always_ff @(posedge clk) begin
		if (adv) begin
			pw_n_s   <= pw_prod_c[31:24];
			pw_f_s   <= pw_prod_c[23:8];
			pw_frc_s <= lf_frc_s;
		end
	end

	// ------------------------------------------------------------------
	// Exp2 of the fraction: sixteen chained square roots
	// ------------------------------------------------------------------
	sqrt_acc_t   ex_acc_s [EX_STAGES];
	logic [32:0] ex_r_s   [EX_STAGES];
	logic [15:0] ex_g_s   [EX_STAGES];
	logic [7:0]  ex_n_s   [EX_STAGES];
	logic        ex_fz_s  [EX_STAGES];
	att_force_t  ex_frc_s [EX_STAGES];

	for (genvar e = 0; e < EX_STAGES; e++) begin : g_ex
		localparam int K = e / EXP_SUB;
		localparam int B = e % EXP_SUB;
		logic [15:0] g_in;
		logic [7:0]  n_in;
		logic        fz_in;
		att_force_t  frc_in;
		logic [32:0] r_use;
		sqrt_acc_t   a_in;
		sqrt_acc_t   a_out;
		logic [63:0] rad;
		if (e == 0) begin : g_first
			assign g_in   = ~pw_f_s + 16'd1;
			assign n_in   = pw_n_s;
			assign fz_in  = (pw_f_s == '0);
			assign frc_in = pw_frc_s;
		end else begin : g_next
			assign g_in   = ex_g_s[e-1];
			assign n_in   = ex_n_s[e-1];
			assign fz_in  = ex_fz_s[e-1];
			assign frc_in = ex_frc_s[e-1];
		end
		if (B == 0) begin : g_root_start
			logic [32:0] r_prev;
			if (e == 0) begin : g_seed
				assign r_prev = EXP_ONE;
			end else begin : g_chain
				assign r_prev = {1'b0, ex_acc_s[e-1].root};
			end
			// Double before the root where this bit of g is set
			assign r_use = g_in[K] ? {r_prev[31:0], 1'b0} : r_prev;
			assign a_in  = '0;
		end else begin : g_root_cont
			assign r_use = ex_r_s[e-1];
			assign a_in  = ex_acc_s[e-1];
		end
		assign rad = {1'b0, r_use, 30'b0};
		always_comb begin
			a_out = a_in;
			for (int m = 0; m < EXP_PER; m++) begin
				a_out = sqrt_step(a_out, rad[63-2*(EXP_PER*B+m) -: 2]);
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				ex_acc_s[e] <= a_out;
				ex_r_s[e]   <= r_use;
				ex_g_s[e]   <= g_in;
				ex_n_s[e]   <= n_in;
				ex_fz_s[e]  <= fz_in;
				ex_frc_s[e] <= frc_in;
			end
		end
	end

	// ------------------------------------------------------------------
	// Shift to Q1.15 and apply the early decisions
	// ------------------------------------------------------------------
	logic [8:0]        att_shift_c;
	logic [31:0]       att_root_c;
	logic [GAIN_W-1:0] att_c;
	logic [GAIN_W-1:0] att_s;

	always_comb begin
		att_shift_c = 9'd16 + {1'b0, ex_n_s[EX_STAGES-1]};
		att_root_c  = ex_acc_s[EX_STAGES-1].root >> att_shift_c;
		if (ex_frc_s[EX_STAGES-1].one) begin
			att_c = ONE_Q15;
		end else if (ex_frc_s[EX_STAGES-1].zero) begin
			att_c = '0;
		end else if (ex_fz_s[EX_STAGES-1]) begin
			att_c = ONE_Q15 >> ex_n_s[EX_STAGES-1];
		end else begin
			att_c = att_root_c[GAIN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			att_s <= att_c;
		end
	end

	// ------------------------------------------------------------------
	// Output beat: apply the attenuation to the gain when positional
	// ------------------------------------------------------------------
	logic [2*GAIN_W-1:0] og_prod_c;
	out_beat_t           out_q;

	assign og_prod_c = base_gain_q * att_s;

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.attenuation  <= att_s;
			out_q.applied_gain <= positional_q ? og_prod_c[30:15] : base_gain_q;
		end
	end

	assign out_data = out_q;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	a_att_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.attenuation <= ONE_Q15)
		else $error("attenuation above unity");

	a_plain_gain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !positional_q |-> out_data.applied_gain == base_gain_q)
		else $error("non-positional gain differs from master times channel");

	a_exp_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[V_EXL] |-> ex_acc_s[EX_STAGES-1].root >= 32'h4000_0000 &&
			ex_acc_s[EX_STAGES-1].root <= 32'h8000_0000)
		else $error("exp2 root left [1,2]");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

endmodule
